// ===== hdl/xxh64_pkg.sv =====
// ----------------------------------------------------------------------------
// xxh64_pkg
// Shared constants, micro-operation codes and control types of the
// streaming xxhash64 hasher.
// ----------------------------------------------------------------------------
package xxh64_pkg;

    localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
    localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
    localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
    localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
    localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

    localparam int WORD_BYTES = 8;

    // datapath micro-operations; the multiply ones start the shared multiplier
    typedef enum logic [4:0] {
        U_NONE,
        U_SUM,
        U_SHORT,
        U_ADDLEN,
        U_SHIFT32,
        U_SHIFT8,
        U_DIGEST,
        U_LR1,
        U_LR2,
        U_ML1,
        U_FD1,
        U_XR,
        U_ML3,
        U_FD3,
        U_W4A,
        U_W4B,
        U_B1A,
        U_B1B,
        U_AV1,
        U_AV2
    } uop_t;

    typedef struct packed {
        logic       start;
        uop_t       uop;
        logic [1:0] idx;
        logic       accept;
        logic       load;
        logic [3:0] cnt;
        logic [1:0] pos;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic len_ge32;
    } stat_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        rotl64 = (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic is_mul(input uop_t u);
        is_mul = (u >= U_LR1);
    endfunction

endpackage

// ===== hdl/xxh64_ctrl.sv =====
// ----------------------------------------------------------------------------
// xxh64_ctrl
// Sequencer: takes input transactions, walks the round, merge, fold, tail and
// avalanche steps and hands the digest to the output register.
// ----------------------------------------------------------------------------
module xxh64_ctrl
    import xxh64_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] in_count,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output cmd_t       cmd,
    input  stat_t      stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUND,
        S_HEAD,
        S_SUM,
        S_MERGE,
        S_ADDLEN,
        S_FOLD,
        S_W4,
        S_BYTE,
        S_AVAL,
        S_OUT
    } state_t;

    state_t     state_reg;
    logic [1:0] i_reg;
    logic [1:0] ph_reg;
    logic       wait_reg;
    logic       busy_reg;
    logic       last_reg;
    logic [3:0] cnt_reg;
    logic [2:0] left_reg;
    logic [1:0] pos_reg;
    logic       out_valid_reg;

    logic [3:0] cnt_c;
    uop_t       step_uop;
    logic       step_done;
    state_t     tail_state;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // short counts only count on the last item
    assign cnt_c = (!in_last || in_count > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : in_count;

    always_comb
    begin
        if (cnt_reg[3])
            tail_state = S_AVAL;
        else if (cnt_reg[2])
            tail_state = S_W4;
        else if (cnt_reg != 4'd0)
            tail_state = S_BYTE;
        else
            tail_state = S_AVAL;
    end

    always_comb
    begin
        step_uop = U_NONE;
        unique case (state_reg)
            S_ROUND:  step_uop = (ph_reg == 2'd0) ? U_LR1 : U_LR2;
            S_HEAD:   step_uop = stat.len_ge32 ? U_NONE : U_SHORT;
            S_SUM:    step_uop = U_SUM;
            S_MERGE:  step_uop = (ph_reg == 2'd0) ? U_ML1 : (ph_reg == 2'd1) ? U_XR : U_ML3;
            S_ADDLEN: step_uop = U_ADDLEN;
            S_FOLD:   step_uop = (ph_reg == 2'd0) ? U_FD1 : (ph_reg == 2'd1) ? U_XR : U_FD3;
            S_W4:     step_uop = (ph_reg == 2'd0) ? U_W4A :
                                 (ph_reg == 2'd1) ? U_W4B : U_SHIFT32;
            S_BYTE:   step_uop = (ph_reg == 2'd0) ? U_B1A :
                                 (ph_reg == 2'd1) ? U_B1B : U_SHIFT8;
            S_AVAL:   step_uop = (ph_reg == 2'd0) ? U_AV1 : U_AV2;
            S_OUT:    step_uop = (!out_valid_reg || out_ready) ? U_DIGEST : U_NONE;
            default:  step_uop = U_NONE;
        endcase

        if (is_mul(step_uop))
            step_done = wait_reg && stat.mul_done;
        else
            step_done = (step_uop != U_NONE);

        cmd        = '0;
        cmd.uop    = step_uop;
        cmd.idx    = i_reg;
        cmd.pos    = pos_reg;
        cmd.cnt    = cnt_c;
        cmd.start  = is_mul(step_uop) ? !wait_reg : (step_uop != U_NONE);
        cmd.accept = in_valid && (state_reg == S_IDLE);
        cmd.load   = cmd.accept && !busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= 2'd0;
            ph_reg        <= 2'd0;
            wait_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= 4'd0;
            left_reg      <= 3'd0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !(state_reg == S_OUT && step_done))
                out_valid_reg <= 1'b0;

            if (is_mul(step_uop))
            begin
                if (!wait_reg)
                    wait_reg <= 1'b1;
                else if (stat.mul_done)
                    wait_reg <= 1'b0;
            end

            // remaining tail bytes once the 4-byte step is taken;
            // during the byte steps it counts down after each shift
            if (state_reg != S_BYTE)
                left_reg <= cnt_reg[2] ? {1'b0, cnt_reg[1:0]} : cnt_reg[2:0];
            else if (step_done && ph_reg == 2'd2)
                left_reg <= left_reg - 3'd1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.accept)
                    begin
                        busy_reg <= 1'b1;
                        last_reg <= in_last;
                        cnt_reg  <= cnt_c;
                        i_reg    <= 2'd0;
                        ph_reg   <= 2'd0;
                        if (cnt_c[3] && pos_reg == 2'd3)
                        begin
                            pos_reg   <= 2'd0;
                            state_reg <= S_ROUND;
                        end
                        else
                        begin
                            pos_reg   <= pos_reg + 2'(cnt_c[3]);
                            state_reg <= in_last ? S_HEAD : S_IDLE;
                        end
                    end
                end
                S_ROUND:
                begin
                    if (step_done)
                    begin
                        if (ph_reg == 2'd0)
                            ph_reg <= 2'd1;
                        else
                        begin
                            ph_reg <= 2'd0;
                            i_reg  <= i_reg + 2'd1;
                            if (i_reg == 2'd3)
                                state_reg <= last_reg ? S_HEAD : S_IDLE;
                        end
                    end
                end
                S_HEAD:
                begin
                    i_reg     <= 2'd0;
                    state_reg <= stat.len_ge32 ? S_SUM : S_ADDLEN;
                end
                S_SUM:
                begin
                    i_reg <= i_reg + 2'd1;
                    if (i_reg == 2'd3)
                        state_reg <= S_MERGE;
                end
                S_MERGE:
                begin
                    if (step_done)
                    begin
                        if (ph_reg != 2'd2)
                            ph_reg <= ph_reg + 2'd1;
                        else
                        begin
                            ph_reg <= 2'd0;
                            i_reg  <= i_reg + 2'd1;
                            if (i_reg == 2'd3)
                                state_reg <= S_ADDLEN;
                        end
                    end
                end
                S_ADDLEN:
                begin
                    i_reg     <= 2'd0;
                    ph_reg    <= 2'd0;
                    state_reg <= (pos_reg != 2'd0) ? S_FOLD : tail_state;
                end
                S_FOLD:
                begin
                    if (step_done)
                    begin
                        if (ph_reg != 2'd2)
                            ph_reg <= ph_reg + 2'd1;
                        else
                        begin
                            ph_reg <= 2'd0;
                            i_reg  <= i_reg + 2'd1;
                            if (i_reg == pos_reg - 2'd1)
                                state_reg <= tail_state;
                        end
                    end
                end
                S_W4:
                begin
                    if (step_done)
                    begin
                        if (ph_reg != 2'd2)
                            ph_reg <= ph_reg + 2'd1;
                        else
                        begin
                            ph_reg    <= 2'd0;
                            state_reg <= (left_reg != 3'd0) ? S_BYTE : S_AVAL;
                        end
                    end
                end
                S_BYTE:
                begin
                    if (step_done)
                    begin
                        if (ph_reg != 2'd2)
                            ph_reg <= ph_reg + 2'd1;
                        else
                        begin
                            ph_reg  <= 2'd0;
                            cnt_reg <= {1'b0, left_reg - 3'd1};
                            if (left_reg == 3'd1)
                                state_reg <= S_AVAL;
                        end
                    end
                end
                S_AVAL:
                begin
                    if (step_done)
                    begin
                        if (ph_reg == 2'd0)
                            ph_reg <= 2'd1;
                        else
                        begin
                            ph_reg    <= 2'd0;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (step_done)
                    begin
                        out_valid_reg <= 1'b1;
                        busy_reg      <= 1'b0;
                        pos_reg       <= 2'd0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/xxh64_dp.sv =====
// ----------------------------------------------------------------------------
// xxh64_dp
// Datapath: seed, lane accumulators, stripe buffer, length counter, hash
// register and a shared 64-bit multiplier built from one 32x32 unit.
// ----------------------------------------------------------------------------
module xxh64_dp
    import xxh64_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [63:0] cfg_data,
    input  logic [63:0] word,
    input  cmd_t        cmd,
    output stat_t       stat,
    output logic [63:0] digest
);

    logic [63:0]            seed_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [63:0]            lane_reg [4];
    logic [63:0]            tail_reg [4];
    logic [63:0]            h_reg;
    logic [63:0]            r_reg;
    logic [63:0]            w_reg;
    logic [63:0]            dig_reg;
    logic [63:0]            a_reg;
    logic [63:0]            b_reg;
    logic [63:0]            c_reg;
    logic [63:0]            m_reg;
    uop_t                   op_reg;
    logic [1:0]             idx_reg;
    logic [2:0]             ph_reg;

    logic [63:0] a_c;
    logic [63:0] b_c;
    logic [63:0] masked;
    logic [63:0] sum_rot;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;
    logic        plain;

    assign stat.mul_done = (ph_reg == 3'd4);
    assign stat.len_ge32 = (len_reg >= LENGTH_BITS'(32));
    assign digest        = dig_reg;
    assign plain         = cmd.start && !is_mul(cmd.uop);

    always_comb
    begin
        for (int b = 0; b < WORD_BYTES; b++)
            masked[8*b +: 8] = (4'(b) < cmd.cnt) ? word[8*b +: 8] : 8'd0;
    end

    always_comb
    begin
        case (cmd.idx)
            2'd0:    sum_rot = rotl64(lane_reg[0], 1);
            2'd1:    sum_rot = rotl64(lane_reg[1], 7);
            2'd2:    sum_rot = rotl64(lane_reg[2], 12);
            default: sum_rot = rotl64(lane_reg[3], 18);
        endcase
    end

    // multiplier operands for the operation being started
    always_comb
    begin
        a_c = h_reg;
        b_c = PRIME1;
        case (cmd.uop)
            U_LR1:   begin a_c = tail_reg[cmd.idx];          b_c = PRIME2; end
            U_LR2:   begin a_c = r_reg;                      b_c = PRIME1; end
            U_ML1:   begin a_c = lane_reg[cmd.idx];          b_c = PRIME2; end
            U_FD1:   begin a_c = tail_reg[cmd.idx];          b_c = PRIME2; end
            U_XR:    begin a_c = r_reg;                      b_c = PRIME1; end
            U_ML3:   begin a_c = h_reg;                      b_c = PRIME1; end
            U_FD3:   begin a_c = rotl64(h_reg, 27);          b_c = PRIME1; end
            U_W4A:   begin a_c = {32'd0, w_reg[31:0]};       b_c = PRIME1; end
            U_W4B:   begin a_c = rotl64(h_reg, 23);          b_c = PRIME2; end
            U_B1A:   begin a_c = {56'd0, w_reg[7:0]};        b_c = PRIME5; end
            U_B1B:   begin a_c = rotl64(h_reg, 11);          b_c = PRIME1; end
            U_AV1:   begin a_c = h_reg ^ (h_reg >> 33);      b_c = PRIME2; end
            U_AV2:   begin a_c = h_reg ^ (h_reg >> 29);      b_c = PRIME3; end
            default: begin a_c = h_reg;                      b_c = PRIME1; end
        endcase
    end

    // low 64 bits of the product: lo*lo, then the two cross terms
    assign mx   = (ph_reg == 3'd3) ? a_reg[63:32] : a_reg[31:0];
    assign my   = (ph_reg == 3'd2) ? b_reg[63:32] : b_reg[31:0];
    assign prod = 64'(mx) * 64'(my);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 64'd0;
            len_reg  <= '0;
            ph_reg   <= 3'd0;
        end
        else
        begin
            if (cfg_valid)
                seed_reg <= cfg_data;
            if (cmd.accept)
                len_reg <= (cmd.load ? '0 : len_reg) + LENGTH_BITS'(cmd.cnt);
            if (cmd.start && is_mul(cmd.uop))
                ph_reg <= 3'd1;
            else if (ph_reg == 3'd4)
                ph_reg <= 3'd0;
            else if (ph_reg != 3'd0)
                ph_reg <= ph_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (cmd.load)
            begin
                lane_reg[0] <= seed_reg + PRIME1 + PRIME2;
                lane_reg[1] <= seed_reg + PRIME2;
                lane_reg[2] <= seed_reg;
                lane_reg[3] <= seed_reg - PRIME1;
            end
            if (cmd.cnt[3])
                tail_reg[cmd.pos] <= word;
            w_reg <= masked;
        end

        if (plain)
        begin
            case (cmd.uop)
                U_SUM:     h_reg <= (cmd.idx == 2'd0) ? sum_rot : h_reg + sum_rot;
                U_SHORT:   h_reg <= lane_reg[2] + PRIME5;
                U_ADDLEN:  h_reg <= h_reg + 64'(len_reg);
                U_SHIFT32: w_reg <= w_reg >> 32;
                U_SHIFT8:  w_reg <= w_reg >> 8;
                U_DIGEST:  dig_reg <= h_reg;
                default:   ;
            endcase
        end

        if (cmd.start && is_mul(cmd.uop))
        begin
            a_reg   <= a_c;
            b_reg   <= b_c;
            c_reg   <= lane_reg[cmd.idx];
            op_reg  <= cmd.uop;
            idx_reg <= cmd.idx;
        end

        case (ph_reg)
            3'd1:    m_reg <= prod;
            3'd2,
            3'd3:    m_reg <= m_reg + {prod[31:0], 32'd0};
            default: ;
        endcase

        if (ph_reg == 3'd4)
        begin
            case (op_reg) inside
                U_LR1:               r_reg <= rotl64(c_reg + m_reg, 31);
                U_LR2:               lane_reg[idx_reg] <= m_reg;
                U_ML1, U_FD1:        r_reg <= rotl64(m_reg, 31);
                U_XR, U_W4A, U_B1A:  h_reg <= h_reg ^ m_reg;
                U_ML3, U_FD3:        h_reg <= m_reg + PRIME4;
                U_W4B:               h_reg <= m_reg + PRIME3;
                U_B1B, U_AV1:        h_reg <= m_reg;
                U_AV2:               h_reg <= m_reg ^ (m_reg >> 32);
                default:             ;
            endcase
        end
    end

endmodule

// ===== hdl/xxh64_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_top
// Streaming xxhash64 of a message given as little-endian 64-bit words.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  tdata: data_word[63:0], byte_count[67:64];
//                                          tlast: last
//   m_*      out        m_tvalid/m_tready  tdata: digest[63:0]
//   cfg_*    in         cfg_valid/cfg_ready cfg_data: seed
//
// a word that does not close a stripe needs no multiply and, unless it is
// last, leaves the input ready; the fourth word of a stripe adds 8 multiplies
// on the shared 32x32 multiplier; the last word adds the merge (12 multiplies,
// only from 32 bytes on), 3 per buffered word, 2 per tail step (4-byte or
// 1-byte), 2 for the avalanche, plus the sum, length and shift steps
// the digest sits in an output register; a new message may start while it
// waits, but the next digest stalls until it is taken
// reset clears control state, the seed and the length counter only; no clearing pass
// ----------------------------------------------------------------------------
module xxhash64_stream_hasher_top
    import xxh64_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest[63:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    xxh64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_count  (s_tdata[67:64]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    xxh64_dp #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .word      (s_tdata[63:0]),
        .cmd       (cmd),
        .stat      (stat),
        .digest    (m_tdata)
    );

endmodule
